FILE: hw/rtl/nipd_pkg.sv
// shared types and constants for the nec ir pulse decoder
package nipd_pkg;

    localparam int WIDTH_W     = 16;
    localparam int CFG_IDX_W   = 4;
    localparam int BYTE_W      = 8;
    localparam int BIT_POS_W   = 7;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 48;

    localparam logic [WIDTH_W-1:0] SHORT_MARK_MAX = 16'd70;
    localparam logic [WIDTH_W-1:0] BIT_SPACE_MAX  = 16'd180;
    localparam logic signed [BIT_POS_W-1:0] FRAME_BITS  = 7'sd32;
    localparam logic signed [BIT_POS_W-1:0] BIT_POS_MAX = 7'sd63;
    localparam logic signed [BIT_POS_W-1:0] BIT_POS_IDLE = -7'sd1;
    localparam logic [BYTE_W-1:0] REPEAT_MAX = 8'd255;

    localparam logic [WIDTH_W-1:0] RST_LEADER_MARK_MIN  = 16'd850;
    localparam logic [WIDTH_W-1:0] RST_LEADER_MARK_MAX  = 16'd1000;
    localparam logic [WIDTH_W-1:0] RST_LEADER_SPACE_MIN = 16'd420;
    localparam logic [WIDTH_W-1:0] RST_LEADER_SPACE_MAX = 16'd480;
    localparam logic [WIDTH_W-1:0] RST_REPEAT_SPACE_MIN = 16'd200;
    localparam logic [WIDTH_W-1:0] RST_REPEAT_SPACE_MAX = 16'd260;
    localparam logic [WIDTH_W-1:0] RST_SHORT_PULSE_MIN  = 16'd40;
    localparam logic [WIDTH_W-1:0] RST_ONE_SPACE_MIN    = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LEADER_MARK_MIN  = 4'd0,
        REG_LEADER_MARK_MAX  = 4'd1,
        REG_LEADER_SPACE_MIN = 4'd2,
        REG_LEADER_SPACE_MAX = 4'd3,
        REG_REPEAT_SPACE_MIN = 4'd4,
        REG_REPEAT_SPACE_MAX = 4'd5,
        REG_SHORT_PULSE_MIN  = 4'd6,
        REG_ONE_SPACE_MIN    = 4'd7
    } cfg_idx_t;

    typedef enum logic {
        OP_EDGE    = 1'b0,
        OP_TIMEOUT = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [WIDTH_W-1:0] leader_mark_min;
        logic [WIDTH_W-1:0] leader_mark_max;
        logic [WIDTH_W-1:0] leader_space_min;
        logic [WIDTH_W-1:0] leader_space_max;
        logic [WIDTH_W-1:0] repeat_space_min;
        logic [WIDTH_W-1:0] repeat_space_max;
        logic [WIDTH_W-1:0] short_pulse_min;
        logic [WIDTH_W-1:0] one_space_min;
    } cfg_t;

    typedef struct packed {
        opcode_t            opcode;
        logic               line_level;
        logic [WIDTH_W-1:0] interval_width;
    } event_t;

    typedef struct packed {
        logic [BYTE_W-1:0]              address;
        logic [BYTE_W-1:0]              address_inv;
        logic [BYTE_W-1:0]              command;
        logic [BYTE_W-1:0]              command_inv;
        logic signed [BIT_POS_W-1:0]    bit_position;
        logic                           leader_seen;
        logic                           done_flag;
        logic [BYTE_W-1:0]              repeats;
    } dec_state_t;

endpackage

FILE: hw/rtl/nipd_cfg.sv
// configuration register file for the nec ir pulse decoder
module nipd_cfg (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [nipd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [nipd_pkg::WIDTH_W-1:0]   cfg_data,
    output nipd_pkg::cfg_t              cfg
);
    import nipd_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.leader_mark_min  <= RST_LEADER_MARK_MIN;
            cfg_reg.leader_mark_max  <= RST_LEADER_MARK_MAX;
            cfg_reg.leader_space_min <= RST_LEADER_SPACE_MIN;
            cfg_reg.leader_space_max <= RST_LEADER_SPACE_MAX;
            cfg_reg.repeat_space_min <= RST_REPEAT_SPACE_MIN;
            cfg_reg.repeat_space_max <= RST_REPEAT_SPACE_MAX;
            cfg_reg.short_pulse_min  <= RST_SHORT_PULSE_MIN;
            cfg_reg.one_space_min    <= RST_ONE_SPACE_MIN;
        end else if (cfg_we) begin
            // indexes beyond the register list fall to the default arm
            case (cfg_index)
                REG_LEADER_MARK_MIN:  cfg_reg.leader_mark_min  <= cfg_data;
                REG_LEADER_MARK_MAX:  cfg_reg.leader_mark_max  <= cfg_data;
                REG_LEADER_SPACE_MIN: cfg_reg.leader_space_min <= cfg_data;
                REG_LEADER_SPACE_MAX: cfg_reg.leader_space_max <= cfg_data;
                REG_REPEAT_SPACE_MIN: cfg_reg.repeat_space_min <= cfg_data;
                REG_REPEAT_SPACE_MAX: cfg_reg.repeat_space_max <= cfg_data;
                REG_SHORT_PULSE_MIN:  cfg_reg.short_pulse_min  <= cfg_data;
                REG_ONE_SPACE_MIN:    cfg_reg.one_space_min    <= cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: hw/rtl/nipd_core.sv
// next-state logic: applies one event to the decoder state
module nipd_core (
    input  nipd_pkg::cfg_t       cfg,
    input  nipd_pkg::event_t     ev,
    input  nipd_pkg::dec_state_t cur,
    output nipd_pkg::dec_state_t nxt
);
    import nipd_pkg::*;

    function automatic logic in_range(input logic [WIDTH_W-1:0] w,
                                      input logic [WIDTH_W-1:0] lo,
                                      input logic [WIDTH_W-1:0] hi);
        return (w > lo) && (w < hi);
    endfunction

    logic               lvl;
    logic [WIDTH_W-1:0] w;
    logic               is_one;
    logic [4:0]         pos;

    assign lvl    = ev.line_level;
    assign w      = ev.interval_width;
    assign is_one = w > cfg.one_space_min;

    // rules apply in order, each sees the effects of the earlier ones
    always_comb begin
        nxt = cur;
        pos = 5'd0;
        if (ev.opcode == OP_TIMEOUT) begin
            nxt = '0;
        end else begin
            if (lvl && in_range(w, cfg.leader_mark_min, cfg.leader_mark_max)) begin
                nxt.leader_seen = 1'b1;
                nxt.done_flag   = 1'b0;
            end
            if (!lvl && nxt.leader_seen
                && in_range(w, cfg.leader_space_min, cfg.leader_space_max)) begin
                nxt.bit_position = BIT_POS_IDLE;
                nxt.repeats      = '0;
                nxt.leader_seen  = 1'b0;
            end
            if (!lvl && nxt.leader_seen
                && in_range(w, cfg.repeat_space_min, cfg.repeat_space_max)) begin
                nxt.bit_position = BIT_POS_IDLE;
                nxt.leader_seen  = 1'b0;
                if (nxt.repeats != REPEAT_MAX) begin
                    nxt.repeats = nxt.repeats + 8'd1;
                end
                nxt.done_flag = 1'b1;
            end
            if (lvl && in_range(w, cfg.short_pulse_min, SHORT_MARK_MAX)) begin
                if (nxt.bit_position < BIT_POS_MAX) begin
                    nxt.bit_position = nxt.bit_position + 7'sd1;
                end
            end
            if (!lvl && in_range(w, cfg.short_pulse_min, BIT_SPACE_MAX)
                && !nxt.bit_position[BIT_POS_W-1] && (nxt.bit_position < FRAME_BITS)) begin
                pos = nxt.bit_position[4:0];
                case (pos[4:3])
                    2'd0:    nxt.address[pos[2:0]]     = is_one;
                    2'd1:    nxt.address_inv[pos[2:0]] = is_one;
                    2'd2:    nxt.command[pos[2:0]]     = is_one;
                    default: nxt.command_inv[pos[2:0]] = is_one;
                endcase
            end
            if (nxt.bit_position == FRAME_BITS) begin
                nxt.done_flag = 1'b1;
            end
        end
    end

endmodule

FILE: hw/rtl/nec_ir_pulse_decoder.sv
// top level of the nec ir pulse decoder: input register, state, result register
// Decodes NEC infrared frames from edge and timeout events, one word in and one
// word out per event. A word is captured in the input register, then applied to
// the decoder state while the result is written to the output register, so the
// block sustains one word per clock while the master side accepts results. Both
// stages hold while the result waits, so a stall on the master side reaches
// s_tready in the same cycle. The user must write the eight width thresholds
// via cfg_we/cfg_index/cfg_data only while idle; the block does not enforce it.
module nec_ir_pulse_decoder (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [nipd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [nipd_pkg::WIDTH_W-1:0]    cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // [0] line_level, [16:1] interval_width, [23:17] zero
    input  logic [nipd_pkg::S_TDATA_W-1:0]  s_tdata,
    // [0] opcode
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // [7:0] address, [15:8] address_inverse, [23:16] command,
    // [31:24] command_inverse, [32] frame_done, [40:33] repeat_count, [47:41] zero
    output logic [nipd_pkg::M_TDATA_W-1:0]  m_tdata
);
    import nipd_pkg::*;

    cfg_t       cfg;
    event_t     ev_reg;
    logic       ev_valid_reg;
    dec_state_t st_reg;
    dec_state_t st_next;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic       out_valid_reg;
    logic       advance;

    nipd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    nipd_core u_core (
        .cfg (cfg),
        .ev  (ev_reg),
        .cur (st_reg),
        .nxt (st_next)
    );

    assign advance  = !out_valid_reg || m_tready;
    assign s_tready = !ev_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ev_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            st_reg        <= '0;
        end else begin
            if (s_tready) begin
                ev_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= ev_valid_reg;
                if (ev_valid_reg) begin
                    st_reg <= st_next;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            ev_reg.opcode         <= opcode_t'(s_tuser);
            ev_reg.line_level     <= s_tdata[0];
            ev_reg.interval_width <= s_tdata[WIDTH_W:1];
        end
        if (advance && ev_valid_reg) begin
            out_data_reg <= {7'd0, st_next.repeats, st_next.done_flag,
                             st_next.command_inv, st_next.command,
                             st_next.address_inv, st_next.address};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

FILE: dv/testbench.sv
// self-checking testbench for the nec ir pulse decoder
`timescale 1ns / 100ps

module testbench;
    import nipd_pkg::*;

    localparam logic [CFG_IDX_W-1:0] IDX_FIRST_UNUSED = 4'd8;

    typedef struct {
        logic [BYTE_W-1:0] address;
        logic [BYTE_W-1:0] address_inverse;
        logic [BYTE_W-1:0] command;
        logic [BYTE_W-1:0] command_inverse;
        logic              frame_done;
        logic [BYTE_W-1:0] repeat_count;
    } ir_decode_t;

    logic                   aclk;
    logic                   aresetn   = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WIDTH_W-1:0]     cfg_data  = '0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    // [0] line_level, [16:1] interval_width, [23:17] zero
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    // [0] opcode
    logic                   s_tuser   = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    // [7:0] address, [15:8] address_inverse, [23:16] command,
    // [31:24] command_inverse, [32] frame_done, [40:33] repeat_count, [47:41] zero
    logic [M_TDATA_W-1:0]   m_tdata;

    nec_ir_pulse_decoder DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // decoder state mirrored by the testbench
    cfg_t              thr;
    logic [BYTE_W-1:0] addr_q, addr_inv_q, cmd_q, cmd_inv_q, rpt_q;
    int                bit_pos;
    logic              leader_armed, done_q;

    ir_decode_t pending_decodes[$];
    bit         stalls_on = 1'b1;
    int         errors, events_sent, results_checked;
    int         frames_sent, repeat_codes_sent, settings_applied;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("nec_ir_pulse_decoder test failed");
        $finish;
    end

    function automatic void clear_decoder(); 
        addr_q       = '0;
        addr_inv_q   = '0;
        cmd_q        = '0;
        cmd_inv_q    = '0;
        rpt_q        = '0;
        bit_pos      = 0;
        leader_armed = 1'b0;
        done_q       = 1'b0;
    endfunction

    function automatic bit in_window(int w, int lo, int hi);
        return w > lo && w < hi;
    endfunction

    // applies one event to the mirrored state and returns the decoder outputs after it
    function automatic ir_decode_t decode_event(opcode_t op, logic lvl, logic [WIDTH_W-1:0] w);
        ir_decode_t r;
        logic       one;
        if (op == OP_TIMEOUT) begin
            clear_decoder();
        end else begin
            if (lvl && in_window(w, thr.leader_mark_min, thr.leader_mark_max)) begin
                leader_armed = 1'b1;
                done_q       = 1'b0;
            end
            if (!lvl && leader_armed
                && in_window(w, thr.leader_space_min, thr.leader_space_max)) begin
                bit_pos      = BIT_POS_IDLE;
                rpt_q        = '0;
                leader_armed = 1'b0;
            end
            if (!lvl && leader_armed
                && in_window(w, thr.repeat_space_min, thr.repeat_space_max)) begin
                bit_pos      = BIT_POS_IDLE;
                leader_armed = 1'b0;
                if (rpt_q != REPEAT_MAX) rpt_q++;
                done_q       = 1'b1;
            end
            if (lvl && in_window(w, thr.short_pulse_min, SHORT_MARK_MAX)) begin
                if (bit_pos < BIT_POS_MAX) bit_pos++;
            end
            if (!lvl && in_window(w, thr.short_pulse_min, BIT_SPACE_MAX)
                && bit_pos >= 0 && bit_pos < FRAME_BITS) begin
                one = w > thr.one_space_min;
                case (bit_pos / 8)
                    0:       addr_q[bit_pos % 8]     = one;
                    1:       addr_inv_q[bit_pos % 8] = one;
                    2:       cmd_q[bit_pos % 8]      = one;
                    default: cmd_inv_q[bit_pos % 8]  = one;
                endcase
            end
            if (bit_pos == FRAME_BITS) done_q = 1'b1;
        end
        r.address         = addr_q;
        r.address_inverse = addr_inv_q;
        r.command         = cmd_q;
        r.command_inverse = cmd_inv_q;
        r.frame_done      = done_q;
        r.repeat_count    = rpt_q;
        return r;
    endfunction

    function automatic cfg_t thresholds(int lm_lo, int lm_hi, int ls_lo, int ls_hi,
                                        int rs_lo, int rs_hi, int sp_lo, int one_lo);
        cfg_t c;
        c.leader_mark_min  = 16'(lm_lo);
        c.leader_mark_max  = 16'(lm_hi);
        c.leader_space_min = 16'(ls_lo);
        c.leader_space_max = 16'(ls_hi);
        c.repeat_space_min = 16'(rs_lo);
        c.repeat_space_max = 16'(rs_hi);
        c.short_pulse_min  = 16'(sp_lo);
        c.one_space_min    = 16'(one_lo);
        return c;
    endfunction

    // a width strictly inside (lo, hi), or any width when that window is empty
    function automatic logic [WIDTH_W-1:0] width_between(int lo, int hi);
        if (hi - lo > 1) return 16'($urandom_range(lo + 1, hi - 1));
        return 16'($urandom);
    endfunction

    function automatic logic [WIDTH_W-1:0] mark_width();
        return width_between(thr.short_pulse_min, SHORT_MARK_MAX);
    endfunction

    function automatic logic [WIDTH_W-1:0] space_width(logic one);
        int lo, hi, split;
        lo    = thr.short_pulse_min;
        hi    = BIT_SPACE_MAX;
        split = thr.one_space_min;
        if (one) return width_between(split > lo ? split : lo, hi);
        return width_between(lo, split + 1 < hi ? split + 1 : hi);
    endfunction

    // noise biased toward the window edges
    function automatic logic [WIDTH_W-1:0] noise_width();
        int k;
        k = $urandom_range(0, 7);
        case ($urandom_range(0, 4))
            0: return 16'($urandom);
            1: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            2: return 16'(int'(thr[k*WIDTH_W +: WIDTH_W]) + $urandom_range(0, 2) - 1);
            3: return 16'($urandom_range(0, 1100));
            default: return 16'(int'($urandom_range(0, 1) ? SHORT_MARK_MAX : BIT_SPACE_MAX)
                                + $urandom_range(0, 2) - 1);
        endcase
    endfunction

    function automatic void check_field(string name, int expected, int actual);
        if (expected != actual) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected, actual);
            errors++;
        end
    endfunction

    always @(posedge aclk) begin
        ir_decode_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_decodes.size() == 0) begin
                $error("result word with no event outstanding: 0x%0h", m_tdata);
                errors++;
            end else begin
                e = pending_decodes.pop_front();
                check_field("address",         e.address,         m_tdata[7:0]);
                check_field("address_inverse", e.address_inverse, m_tdata[15:8]);
                check_field("command",         e.command,         m_tdata[23:16]);
                check_field("command_inverse", e.command_inverse, m_tdata[31:24]);
                check_field("frame_done",      e.frame_done,      m_tdata[32]);
                check_field("repeat_count",    e.repeat_count,    m_tdata[40:33]);
                results_checked++;
            end
        end
    end

    // result side backpressure
    initial begin
        int n;
        wait (aresetn === 1'b1);
        forever begin
            n = stalls_on ? $urandom_range(0, 6) : 0;
            if (n > 0) begin
                m_tready <= 1'b0;
                repeat (n) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_event(opcode_t op, logic lvl, logic [WIDTH_W-1:0] w);
        int gap;
        gap = stalls_on ? $urandom_range(0, 6) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {7'd0, w, lvl};
        do @(posedge aclk); while (!s_tready);
        pending_decodes.push_back(decode_event(op, lvl, w));
        events_sent++;
    endtask

    task automatic send_edge(logic lvl, logic [WIDTH_W-1:0] w);
        send_event(OP_EDGE, lvl, w);
    endtask

    task automatic send_timeout();
        send_event(OP_TIMEOUT, 1'($urandom), 16'($urandom));
    endtask

    // leader, 32 bits lsb first, closing mark; stops once at least cut words are out
    task automatic send_frame(logic [31:0] payload, int cut);
        send_edge(1'b1, width_between(thr.leader_mark_min, thr.leader_mark_max));
        if (cut <= 1) return;
        send_edge(1'b0, width_between(thr.leader_space_min, thr.leader_space_max));
        for (int i = 0; i < 32; i++) begin
            if (2 + 2 * i >= cut) return;
            send_edge(1'b1, mark_width());
            send_edge(1'b0, space_width(payload[i]));
        end
        send_edge(1'b1, mark_width());
        frames_sent++;
    endtask

    task automatic send_repeat_code(bit closing_mark);
        send_edge(1'b1, width_between(thr.leader_mark_min, thr.leader_mark_max));
        send_edge(1'b0, width_between(thr.repeat_space_min, thr.repeat_space_max));
        if (closing_mark) send_edge(1'b1, mark_width());
        repeat_codes_sent++;
    endtask

    function automatic logic [31:0] random_payload();
        logic [7:0] a, c;
        a = 8'($urandom);
        c = 8'($urandom);
        if ($urandom_range(0, 3) == 0) return $urandom;
        return {~c, c, ~a, a};
    endfunction

    // holds the input side until every outstanding word has come back or the wait runs out
    task automatic drain();
        int waited;
        waited = 0;
        s_tvalid <= 1'b0;
        while (pending_decodes.size() != 0 && waited < 2000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (6) @(posedge aclk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [WIDTH_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
    endtask

    task automatic program_thresholds(cfg_t c);
        drain();
        write_reg(REG_LEADER_MARK_MIN,  c.leader_mark_min);
        write_reg(REG_LEADER_MARK_MAX,  c.leader_mark_max);
        write_reg(REG_LEADER_SPACE_MIN, c.leader_space_min);
        write_reg(REG_LEADER_SPACE_MAX, c.leader_space_max);
        write_reg(REG_REPEAT_SPACE_MIN, c.repeat_space_min);
        write_reg(REG_REPEAT_SPACE_MAX, c.repeat_space_max);
        write_reg(REG_SHORT_PULSE_MIN,  c.short_pulse_min);
        write_reg(REG_ONE_SPACE_MIN,    c.one_space_min);
        // an index past the last register must leave everything alone
        write_reg(4'(IDX_FIRST_UNUSED + $urandom_range(0, 7)), 16'($urandom));
        cfg_we <= 1'b0;
        thr = c;
        settings_applied++;
        @(posedge aclk);
    endtask

    task automatic run_traffic(int n_events);
        int stop_at, r;
        stop_at = events_sent + n_events;
        while (events_sent < stop_at) begin
            r = $urandom_range(0, 99);
            if (r < 50) begin
                send_frame(random_payload(), 1000);
            end else if (r < 65) begin
                send_repeat_code($urandom_range(0, 1));
            end else if (r < 78) begin
                send_frame(random_payload(), $urandom_range(1, 66));
                if ($urandom_range(0, 1)) send_timeout();
            end else if (r < 92) begin
                repeat ($urandom_range(1, 5)) send_edge(1'($urandom), noise_width());
            end else begin
                send_timeout();
            end
        end
    endtask

    task automatic test_directed_edges();
        send_event(OP_TIMEOUT, 1'b1, 16'hFFFF);
        send_edge(1'b0, 16'h0000);
        send_edge(1'b1, 16'hFFFF);
        send_edge(1'b0, 16'hFFFF);
        send_edge(1'b1, 16'h0000);
        // bit slot 0 is open straight out of reset
        send_edge(1'b0, 16'd150);
        // leader mark bounds are exclusive
        send_edge(1'b1, 16'd850);
        send_edge(1'b1, 16'd1000);
        send_edge(1'b1, 16'd851);
        send_edge(1'b0, 16'd480);
        send_edge(1'b0, 16'd421);
        // space while no bit slot is open
        send_edge(1'b0, 16'd150);
        send_edge(1'b1, 16'd41);
        send_edge(1'b1, 16'd70);
        send_edge(1'b0, 16'd180);
        send_edge(1'b0, 16'd100);
        send_edge(1'b1, 16'd69);
        send_edge(1'b0, 16'd101);
        // repeat code, then a repeat space with no leader in front
        send_edge(1'b1, 16'd999);
        send_edge(1'b0, 16'd201);
        send_edge(1'b0, 16'd259);
        send_edge(1'b1, 16'd900);
        send_edge(1'b0, 16'd260);
        send_event(OP_TIMEOUT, 1'b0, 16'h0000);
    endtask

    task automatic test_bit_position_saturation();
        send_edge(1'b1, width_between(thr.leader_mark_min, thr.leader_mark_max));
        send_edge(1'b0, width_between(thr.leader_space_min, thr.leader_space_max));
        send_edge(1'b0, space_width(1'b1));
        repeat (70) send_edge(1'b1, mark_width());
        send_edge(1'b0, space_width(1'b1));
        send_timeout();
    endtask

    task automatic test_repeat_saturation();
        stalls_on = 1'b0;
        send_frame(random_payload(), 1000);
        repeat (258) send_repeat_code(1'b0);
        stalls_on = 1'b1;
        repeat (3) send_repeat_code(1'b1);
        send_frame(random_payload(), 1000);
    endtask

    task automatic test_random_traffic();
        run_traffic(200);
        // let every word come back before sending more
        drain();
        stalls_on = 1'b0;
        run_traffic(90);
        stalls_on = 1'b1;
        run_traffic(120);
    endtask

    task automatic test_threshold_sweep();
        int a, b, c;
        program_thresholds(thresholds(0, 0, 0, 0, 0, 0, 0, 0));
        run_traffic(60);
        program_thresholds(thresholds(65535, 65535, 65535, 65535, 65535, 65535,
                                      65535, 65535));
        run_traffic(40);
        // leader mark window swallows short marks, leader space window overlaps repeats
        program_thresholds(thresholds(30, 1000, 200, 480, 150, 260, 20, 60));
        run_traffic(80);
        program_thresholds(thresholds(899, 901, 449, 451, 224, 226, 55, 110));
        stalls_on = 1'b0;
        run_traffic(80);
        stalls_on = 1'b1;
        a = $urandom_range(0, 1200);
        b = $urandom_range(0, 600);
        c = $urandom_range(0, 400);
        program_thresholds(thresholds(a, a + $urandom_range(0, 300), b, b + $urandom_range(0, 200),
                                      c, c + $urandom_range(0, 200), $urandom_range(0, 90),
                                      $urandom_range(0, 200)));
        run_traffic(80);
        program_thresholds(thresholds(RST_LEADER_MARK_MIN, RST_LEADER_MARK_MAX,
                                      RST_LEADER_SPACE_MIN, RST_LEADER_SPACE_MAX,
                                      RST_REPEAT_SPACE_MIN, RST_REPEAT_SPACE_MAX,
                                      RST_SHORT_PULSE_MIN, RST_ONE_SPACE_MIN));
        run_traffic(80);
    endtask

    initial begin
        thr = thresholds(RST_LEADER_MARK_MIN, RST_LEADER_MARK_MAX, RST_LEADER_SPACE_MIN,
                         RST_LEADER_SPACE_MAX, RST_REPEAT_SPACE_MIN, RST_REPEAT_SPACE_MAX,
                         RST_SHORT_PULSE_MIN, RST_ONE_SPACE_MIN);
        clear_decoder();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_edges();
        test_bit_position_saturation();
        test_repeat_saturation();
        test_random_traffic();
        test_threshold_sweep();

        drain();
        if (pending_decodes.size() != 0) begin
            $error("%0d result words never arrived", pending_decodes.size());
            errors++;
        end
        $display("sent %0d events: %0d complete frames, %0d repeat codes, %0d threshold sets",
                 events_sent, frames_sent, repeat_codes_sent, settings_applied);
        $display("compared %0d result words, %0d field mismatches", results_checked, errors);
        if (errors == 0) begin
            $display("nec_ir_pulse_decoder test passed");
        end else begin
            $display("nec_ir_pulse_decoder test failed");
        end
        $finish;
    end

endmodule
